FILE: rtl/mck_pkg.sv
// Shared types, constants and character decoding for the Morse keyer.
`default_nettype none

package mck_pkg;

    // Message store geometry
    localparam int MSG_DEPTH = 64;
    localparam int ADDR_W    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MSG_DEPTH + 1);

    // Timing: unit = DIVIDEND / speed, longest gap is seven units
    localparam int DIVIDEND  = 1200;
    localparam int UNIT_W    = 11;
    localparam int TICK_W    = 14;
    localparam int SPEED_W   = 8;
    localparam int SPEED_RST = 20;
    localparam int UNIT_RST  = DIVIDEND / SPEED_RST;

    localparam logic [7:0] PAT_DONE = 8'h80;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FETCH = 2'd1,
        PH_OUT   = 2'd2,
        PH_NEXT  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_APPEND = 2'd1,
        OP_START  = 2'd2,
        OP_ABORT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CH_END   = 2'd0,
        CH_SPACE = 2'd1,
        CH_SKIP  = 2'd2,
        CH_GLYPH = 2'd3
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [7:0] pattern;
    } glyph_t;

    // Gap and mark lengths in ticks, held ready for the keyer
    typedef struct packed {
        logic [TICK_W-1:0] u1;
        logic [TICK_W-1:0] u2;
        logic [TICK_W-1:0] u3;
        logic [TICK_W-1:0] u5;
        logic [TICK_W-1:0] u7;
    } unit_set_t;

    localparam unit_set_t UNITS_RST = '{
        u1: TICK_W'(UNIT_RST),
        u2: TICK_W'(2 * UNIT_RST),
        u3: TICK_W'(3 * UNIT_RST),
        u5: TICK_W'(5 * UNIT_RST),
        u7: TICK_W'(7 * UNIT_RST)
    };

    // Element patterns from ',' up to 'Z': dash 1, dot 0, then a marker 1
    function automatic logic [7:0] glyph_pattern(input logic [5:0] idx);
        logic [7:0] p;
        case (idx)
            6'd0:  p = 8'hCE;  6'd1:  p = 8'h86;  6'd2:  p = 8'h56;  6'd3:  p = 8'h94;
            6'd4:  p = 8'hFC;  6'd5:  p = 8'h7C;  6'd6:  p = 8'h3C;  6'd7:  p = 8'h1C;
            6'd8:  p = 8'h0C;  6'd9:  p = 8'h04;  6'd10: p = 8'h84;  6'd11: p = 8'hC4;
            6'd12: p = 8'hE4;  6'd13: p = 8'hF4;  6'd14: p = 8'hE2;  6'd15: p = 8'hAA;
            6'd16: p = 8'h80;  6'd17: p = 8'h8C;  6'd18: p = 8'h80;  6'd19: p = 8'h32;
            6'd20: p = 8'h80;  6'd21: p = 8'h60;  6'd22: p = 8'h88;  6'd23: p = 8'hA8;
            6'd24: p = 8'h90;  6'd25: p = 8'h40;  6'd26: p = 8'h28;  6'd27: p = 8'hD0;
            6'd28: p = 8'h08;  6'd29: p = 8'h20;  6'd30: p = 8'h78;  6'd31: p = 8'hB0;
            6'd32: p = 8'h48;  6'd33: p = 8'hE0;  6'd34: p = 8'hA0;  6'd35: p = 8'hF0;
            6'd36: p = 8'h68;  6'd37: p = 8'hD8;  6'd38: p = 8'h50;  6'd39: p = 8'h10;
            6'd40: p = 8'hC0;  6'd41: p = 8'h30;  6'd42: p = 8'h18;  6'd43: p = 8'h70;
            6'd44: p = 8'h98;  6'd45: p = 8'hB8;  6'd46: p = 8'hC8;
            default: p = PAT_DONE;
        endcase
        return p;
    endfunction

    // Classify a stored character and look up its pattern
    function automatic glyph_t glyph_decode(input logic [7:0] c);
        glyph_t     g;
        logic [7:0] up;
        logic [7:0] idx;
        g.kind    = CH_GLYPH;
        g.pattern = PAT_DONE;
        up        = (c >= 8'd97) ? (c - 8'd32) : c;
        idx       = up - 8'd44;
        case (c)
            8'h00: g.kind = CH_END;
            8'h20: g.kind = CH_SPACE;
            8'h03: g.pattern = 8'h54;   // AR
            8'h04: g.pattern = 8'h16;   // VA
            8'h16: g.pattern = 8'h8C;   // BT
            8'h10: g.pattern = 8'h8B;   // BK
            8'h17: g.pattern = 8'hB4;   // KN
            8'h1B: g.pattern = 8'h44;   // AS
            8'h08: g.pattern = 8'h58;   // AA
            default:
            begin
                if (c < 8'd44 || c > 8'd122 || (c >= 8'd91 && c <= 8'd96))
                begin
                    g.kind = CH_SKIP;
                end
                else
                begin
                    g.pattern = glyph_pattern(idx[5:0]);
                end
            end
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mck_unit_div.sv
// Serial divider that turns the speed setting into unit and gap lengths.
`default_nettype none

module mck_unit_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [mck_pkg::SPEED_W-1:0] cfg_wdata,
    output logic                             busy,
    output mck_pkg::unit_set_t               units
);
    import mck_pkg::*;

    localparam int STEPS = UNIT_W;
    localparam int CW    = $clog2(STEPS + 2);

    logic [CW-1:0]      cnt_reg;
    unit_set_t          units_reg;
    logic [SPEED_W-1:0] div_reg;
    logic [SPEED_W-1:0] rem_reg;
    logic [UNIT_W-1:0]  quo_reg;

    logic [SPEED_W:0]   trial;
    logic               ge;
    logic [SPEED_W-1:0] rem_next;
    logic [UNIT_W-1:0]  quo_next;
    logic [TICK_W-1:0]  qx;
    unit_set_t          units_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[UNIT_W-1]};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? SPEED_W'(trial - {1'b0, div_reg}) : trial[SPEED_W-1:0];
        quo_next = {quo_reg[UNIT_W-2:0], ge};
    end

    always_comb
    begin
        qx            = TICK_W'(quo_reg);
        units_next.u1 = qx;
        units_next.u2 = qx << 1;
        units_next.u3 = (qx << 1) + qx;
        units_next.u5 = (qx << 2) + qx;
        units_next.u7 = (qx << 3) - qx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            units_reg <= UNITS_RST;
        end
        else if (cfg_we)
        begin
            cnt_reg <= CW'(STEPS + 1);
        end
        else if (cnt_reg > CW'(1))
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
        else if (cnt_reg == CW'(1))
        begin
            units_reg <= units_next;
            cnt_reg   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            div_reg <= (cfg_wdata == '0) ? SPEED_W'(1) : cfg_wdata;
            quo_reg <= UNIT_W'(DIVIDEND);
            rem_reg <= '0;
        end
        else if (cnt_reg > CW'(1))
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy  = (cnt_reg != '0);
    assign units = units_reg;

endmodule

`default_nettype wire

FILE: rtl/mck_msg_store.sv
// Message character store with a registered read port and write bypass.
`default_nettype none

module mck_msg_store (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [mck_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                 wr_data,
    input  wire logic [mck_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                      rd_data
);
    import mck_pkg::*;

    logic [7:0] mem [MSG_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hand the fresh byte through when it lands on the address being read
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/morse_code_keyer_unit.sv
// Top level of the Morse keyer: item handling, send sequencer and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tuser: op; s_tdata: char_code
//  m_*     | out       | m_tvalid / m_tready | m_tdata: key_out, busy_res, status
//  cfg_*   | in        | cfg_we              | cfg_wdata: speed_wpm
//
// Each beat is applied in a single pass; a beat can be taken every cycle while
// the divider is idle. The result sits in one output register, and the next
// beat is taken in the same cycle that register is drained. A speed write
// runs a serial divider, during which s_tready stays low.
// Reset clears the sequencer, counters and store length; speed resets to 20.
// A stall on m_tready holds the result and stops input only while it is full.
`default_nettype none

module morse_code_keyer_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // speed setting
    input  wire logic                        cfg_we,
    input  wire logic [mck_pkg::SPEED_W-1:0] cfg_wdata,   // [7:0] speed_wpm
    // item input
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,     // [7:0] char_code
    input  wire logic [1:0]                  s_tuser,     // [1:0] op
    // result output
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata      // [0] key_out, [1] busy_res,
                                                          // [3:2] status, [7:4] zero
);
    import mck_pkg::*;

    // sequencer state
    phase_t             phase_reg,  phase_next;
    logic [TICK_W-1:0]  mark_reg,   mark_next;
    logic [TICK_W-1:0]  space_reg,  space_next;
    logic [7:0]         pat_reg,    pat_next;
    logic [CNT_W-1:0]   ridx_reg,   ridx_next;
    logic [CNT_W-1:0]   len_reg,    len_next;
    logic               abort_reg,  abort_next;
    logic               key_reg,    key_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg,  m_data_next;

    logic               div_busy;
    unit_set_t          units;
    logic               accept;
    op_t                op;
    status_t            status;
    logic               wr_en;
    logic [7:0]         cur_char;
    glyph_t             glyph;

    mck_unit_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (div_busy),
        .units     (units)
    );

    // The read port always tracks the next read index, so cur_char is the
    // character at ridx_reg whenever the sequencer looks at it.
    mck_msg_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (ridx_next[ADDR_W-1:0]),
        .rd_data (cur_char)
    );

    assign s_tready = !div_busy && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign glyph    = glyph_decode(cur_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            mark_reg    <= '0;
            space_reg   <= '0;
            pat_reg     <= '0;
            ridx_reg    <= '0;
            len_reg     <= '0;
            abort_reg   <= 1'b0;
            key_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            mark_reg    <= mark_next;
            space_reg   <= space_next;
            pat_reg     <= pat_next;
            ridx_reg    <= ridx_next;
            len_reg     <= len_next;
            abort_reg   <= abort_next;
            key_reg     <= key_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    // Apply one beat: counters and pattern step in a single pass
    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        space_next = space_reg;
        pat_next   = pat_reg;
        ridx_next  = ridx_reg;
        len_next   = len_reg;
        abort_next = abort_reg;
        key_next   = key_reg;
        status     = ST_OK;
        wr_en      = 1'b0;

        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    // a pending abort wins before any timing
                    if (abort_next)
                    begin
                        key_next   = 1'b0;
                        phase_next = PH_IDLE;
                        len_next   = '0;
                        abort_next = 1'b0;
                    end
                    // count the mark down, or drop the key and count the space
                    if (mark_next == '0)
                    begin
                        if (phase_next != PH_IDLE)
                        begin
                            key_next = 1'b0;
                        end
                        if (space_next != '0)
                        begin
                            space_next = space_next - TICK_W'(1);
                        end
                    end
                    else
                    begin
                        mark_next = mark_next - TICK_W'(1);
                    end
                    // both timers out: advance the sequencer one step
                    if (mark_next == '0 && space_next == '0)
                    begin
                        case (phase_next)
                            PH_FETCH:
                            begin
                                if (ridx_next >= len_next)
                                begin
                                    phase_next = PH_IDLE;
                                    len_next   = '0;
                                end
                                else
                                begin
                                    case (glyph.kind)
                                        CH_END:
                                        begin
                                            phase_next = PH_IDLE;
                                            len_next   = '0;
                                        end
                                        CH_SPACE:
                                        begin
                                            space_next = units.u7;
                                            phase_next = PH_NEXT;
                                        end
                                        CH_SKIP:
                                        begin
                                            space_next = units.u5;
                                            phase_next = PH_NEXT;
                                        end
                                        default:
                                        begin
                                            pat_next   = glyph.pattern;
                                            phase_next = PH_OUT;
                                        end
                                    endcase
                                end
                            end
                            PH_OUT:
                            begin
                                if (pat_next == PAT_DONE)
                                begin
                                    // close the character with two more units
                                    space_next = units.u2;
                                    phase_next = PH_NEXT;
                                end
                                else
                                begin
                                    mark_next  = pat_next[7] ? units.u3 : units.u1;
                                    key_next   = 1'b1;
                                    pat_next   = {pat_next[6:0], 1'b0};
                                    space_next = units.u1;
                                end
                            end
                            PH_NEXT:
                            begin
                                ridx_next  = ridx_next + CNT_W'(1);
                                phase_next = PH_FETCH;
                            end
                            default:
                            begin
                                // idle pacing: hold off a start by a word gap
                                space_next = units.u7;
                            end
                        endcase
                    end
                end
                OP_APPEND:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        status = ST_BUSY;
                    end
                    else if (len_reg >= CNT_W'(MSG_DEPTH))
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + CNT_W'(1);
                    end
                end
                OP_START:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        status = ST_BUSY;
                    end
                    else
                    begin
                        ridx_next  = '0;
                        phase_next = PH_FETCH;
                    end
                end
                default:
                begin
                    abort_next = 1'b1;
                end
            endcase
        end
    end

    // Result register: load on every accepted beat, drop once taken
    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, status, (phase_next != PH_IDLE), key_next};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The store only grows while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (phase_reg == PH_IDLE))
        else $error("message store written while sending");

    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(MSG_DEPTH))
        else $error("message length beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (ridx_reg <= len_reg))
        else $error("read index past message end while sending");

    // The key only comes on together with a loaded mark time
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_reg) |-> (mark_reg != '0))
        else $error("key raised without a mark time");

endmodule

`default_nettype wire
